// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the convolution filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge out of reset.
`define CMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never occur out of reset.
`define CMF_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: hw/rtl/cmf_pkg.sv
// Types, constants and helper functions of the convolution filter.
package cmf_pkg;

  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned MAX_ORDER   = 8;
  localparam int unsigned ROW_BITS    = 16;
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W      = $clog2(MAX_ORDER);
  localparam int unsigned LINE_DEPTH  = MAX_WIDTH * MAX_ORDER;
  localparam int unsigned LINE_AW     = $clog2(LINE_DEPTH);
  localparam int unsigned WT_DEPTH    = 64;
  localparam int unsigned WT_AW       = $clog2(WT_DEPTH);
  localparam int unsigned ACC_W       = 34;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Register map indexes
  localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
  localparam logic [2:0] REG_KERNEL_COLS = 3'd1;
  localparam logic [2:0] REG_KERNEL_ROWS = 3'd2;
  localparam logic [2:0] REG_ANCHOR_COL  = 3'd3;
  localparam logic [2:0] REG_ANCHOR_ROW  = 3'd4;
  localparam logic [2:0] REG_DIV_RECIP   = 3'd5;
  localparam logic [2:0] REG_BIAS        = 3'd6;
  localparam logic [2:0] REG_KEEP_ALPHA  = 3'd7;

  typedef enum logic {
    OP_PIXEL  = 1'b0,
    OP_WEIGHT = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_TAP,
    S_DRAIN,
    S_ALPHA,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_OUT
  } back_state_e;

  typedef struct packed {
    logic               operation;
    logic [31:0]        pixel_in;
    logic               start_of_frame;
    logic [5:0]         weight_index;
    logic signed [19:0] weight_value;
  } cmf_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic [10:0] out_col;
    logic [15:0] out_row;
    logic        last;
  } cmf_out_t;

  typedef struct packed {
    logic [11:0]        frame_width;
    logic [3:0]         kernel_cols;
    logic [3:0]         kernel_rows;
    logic [2:0]         anchor_col;
    logic [2:0]         anchor_row;
    logic signed [24:0] divisor_reciprocal;
    logic signed [19:0] bias_offset;
    logic               keep_alpha;
  } cmf_cfg_t;

  // Command from the front end to the back end
  typedef struct packed {
    op_e                 op;
    logic [31:0]         pixel;
    logic [COL_W-1:0]    col;
    logic [SLOT_W-1:0]   slot;
    logic [COL_W-1:0]    first;
    logic [CNT_W-1:0]    count;
    logic [ROW_BITS-1:0] orow;
    logic [WT_AW-1:0]    widx;
    logic signed [19:0]  wval;
  } cmf_cmd_t;

  function automatic logic [COL_W:0] eff_width(logic [11:0] fw);
    logic [COL_W:0] res;
    if (fw == 12'd0) begin
      res = (COL_W+1)'(1);
    end else if (32'(fw) > MAX_WIDTH) begin
      res = (COL_W+1)'(MAX_WIDTH);
    end else begin
      res = (COL_W+1)'(fw);
    end
    return res;
  endfunction

  function automatic logic [3:0] eff_size(logic [3:0] k);
    logic [3:0] res;
    if (k == 4'd0) begin
      res = 4'd1;
    end else if (32'(k) > MAX_ORDER) begin
      res = 4'(MAX_ORDER);
    end else begin
      res = k;
    end
    return res;
  endfunction

  function automatic logic [2:0] eff_anchor(logic [2:0] a, logic [3:0] k);
    logic [2:0] res;
    if ({1'b0, a} < k) begin
      res = a;
    end else begin
      res = 3'(k - 4'd1);
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/convolve_matrix_filter_top.sv
// Throughput is set by the back end walking kernel taps one per cycle over
//   the line buffer RAM port, and by output back-pressure; weight items and
//   silent pixels only write a RAM and produce no result.
// Reset clears counters, queue and control state; config registers reset to
//   their defaults. Line buffers and weights are undefined until written.
module convolve_matrix_filter_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmf_pkg::cmf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cmf_pkg::cmf_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import cmf_pkg::*;

  cmf_cfg_t cfg_q;
  cmf_cmd_t push_cmd, pop_cmd;
  logic     push_valid, push_ready, pop_valid, pop_ready;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width        <= 12'd1;
      cfg_q.kernel_cols        <= 4'd3;
      cfg_q.kernel_rows        <= 4'd3;
      cfg_q.anchor_col         <= 3'd1;
      cfg_q.anchor_row         <= 3'd1;
      cfg_q.divisor_reciprocal <= 25'sd65536;
      cfg_q.bias_offset        <= '0;
      cfg_q.keep_alpha         <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_FRAME_WIDTH: cfg_q.frame_width        <= pwdata[11:0];
        REG_KERNEL_COLS: cfg_q.kernel_cols        <= pwdata[3:0];
        REG_KERNEL_ROWS: cfg_q.kernel_rows        <= pwdata[3:0];
        REG_ANCHOR_COL:  cfg_q.anchor_col         <= pwdata[2:0];
        REG_ANCHOR_ROW:  cfg_q.anchor_row         <= pwdata[2:0];
        REG_DIV_RECIP:   cfg_q.divisor_reciprocal <= pwdata[24:0];
        REG_BIAS:        cfg_q.bias_offset        <= pwdata[19:0];
        REG_KEEP_ALPHA:  cfg_q.keep_alpha         <= pwdata[0];
        default:         cfg_q.keep_alpha         <= cfg_q.keep_alpha;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      REG_FRAME_WIDTH: prdata = {20'd0, cfg_q.frame_width};
      REG_KERNEL_COLS: prdata = {28'd0, cfg_q.kernel_cols};
      REG_KERNEL_ROWS: prdata = {28'd0, cfg_q.kernel_rows};
      REG_ANCHOR_COL:  prdata = {29'd0, cfg_q.anchor_col};
      REG_ANCHOR_ROW:  prdata = {29'd0, cfg_q.anchor_row};
      REG_DIV_RECIP:   prdata = {7'd0, cfg_q.divisor_reciprocal};
      REG_BIAS:        prdata = {12'd0, cfg_q.bias_offset};
      REG_KEEP_ALPHA:  prdata = {31'd0, cfg_q.keep_alpha};
      default:         prdata = '0;
    endcase
  end

  cmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_o       (push_cmd)
  );

  cmf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_cmd)
  );

  cmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/cmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/cmf_front.sv
// Front end: takes input items, tracks row and column, plans output columns.
module cmf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmf_pkg::cmf_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmf_pkg::cmf_in_t  in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmf_pkg::cmf_cmd_t cmd_o
);
  import cmf_pkg::*;

  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [SLOT_W-1:0]   ring_q, ring_d;

  logic [COL_W:0]      w;
  logic [3:0]          kc, kr;
  logic [2:0]          ac, ar, d, dr;
  logic [COL_W-1:0]    col_cur, c, wm1, first;
  logic [ROW_BITS-1:0] row_cur;
  logic [SLOT_W-1:0]   ring_cur;
  logic                last_col, row_ok, is_pixel, xfer;
  logic [COL_W:0]      span;

  assign is_pixel    = (op_e'(in_data_i.operation) == OP_PIXEL);
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign xfer        = in_valid_i && cmd_ready_i;

  // Effective geometry
  always_comb begin
    w   = eff_width(cfg_i.frame_width);
    kc  = eff_size(cfg_i.kernel_cols);
    kr  = eff_size(cfg_i.kernel_rows);
    ac  = eff_anchor(cfg_i.anchor_col, kc);
    ar  = eff_anchor(cfg_i.anchor_row, kr);
    d   = 3'(kc - 4'd1 - {1'b0, ac});
    dr  = 3'(kr - 4'd1 - {1'b0, ar});
    wm1 = COL_W'(w - (COL_W+1)'(1));
  end

  // Position of this pixel and the output columns it completes
  always_comb begin
    col_cur  = in_data_i.start_of_frame ? '0 : col_q;
    row_cur  = in_data_i.start_of_frame ? '0 : row_q;
    ring_cur = in_data_i.start_of_frame ? '0 : ring_q;
    c        = ({1'b0, col_cur} >= w) ? wm1 : col_cur;
    last_col = (c == wm1);
    row_ok   = (row_cur >= ROW_BITS'(kr - 4'd1));
    first    = (c >= COL_W'(d)) ? c - COL_W'(d) : '0;
    span     = w - {1'b0, first};

    cmd_o       = '0;
    cmd_o.op    = op_e'(in_data_i.operation);
    cmd_o.pixel = in_data_i.pixel_in;
    cmd_o.col   = c;
    cmd_o.slot  = ring_cur;
    cmd_o.first = first;
    cmd_o.orow  = row_cur - ROW_BITS'(dr);
    cmd_o.widx  = in_data_i.weight_index;
    cmd_o.wval  = in_data_i.weight_value;
    if (!row_ok) begin
      cmd_o.count = '0;
    end else if (last_col) begin
      cmd_o.count = CNT_W'(span);
    end else if (c >= COL_W'(d)) begin
      cmd_o.count = CNT_W'(1);
    end else begin
      cmd_o.count = '0;
    end
  end

  // Counter update on a pixel transfer
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    ring_d = ring_q;
    if (xfer && is_pixel) begin
      if (last_col) begin
        col_d  = '0;
        row_d  = row_cur + ROW_BITS'(1);
        ring_d = ring_cur + SLOT_W'(1);
      end else begin
        col_d  = c + COL_W'(1);
        row_d  = row_cur;
        ring_d = ring_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ring_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ring_q <= ring_d;
    end
  end

endmodule

// File: hw/rtl/cmf_fifo.sv
// Short command queue between the front end and the back end.
`include "assert_macros.svh"
module cmf_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  cmf_pkg::cmf_cmd_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output cmf_pkg::cmf_cmd_t pop_data_o
);
  import cmf_pkg::*;

  cmf_cmd_t             entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]    count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QUEUE_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QUEUE_AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + (QUEUE_AW+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `CMF_NEVER(fifo_overfill, count_q > (QUEUE_AW+1)'(QUEUE_DEPTH))
  `CMF_ASSERT(fifo_ptr_gap, (wr_ptr_q - rd_ptr_q) == QUEUE_AW'(count_q))
  `CMF_ASSERT(fifo_push_grows, push && !pop |=> count_q == $past(count_q) + 1'b1)

endmodule

// File: hw/rtl/cmf_back.sv
// Back end: executes queued commands, convolves one output pixel at a time.
`include "assert_macros.svh"
module cmf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmf_pkg::cmf_cfg_t cfg_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmf_pkg::cmf_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cmf_pkg::cmf_out_t out_data_o
);
  import cmf_pkg::*;

  back_state_e state_q, state_d;

  cmf_cmd_t                cmd_q;
  logic [COL_W-1:0]        x_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [2:0]              kx_q, ky_q;
  logic [WT_AW-1:0]        widx_q;
  logic [SLOT_W-1:0]       base_q, slot_q;
  logic                    tap_vld_q;
  logic signed [ACC_W-1:0] acc_q [4];
  logic [1:0]              ch_q;
  logic [31:0]             alpha_q;
  logic [7:0]              res_q [4];
  logic signed [42:0]      lo_prod_q;
  logic signed [41:0]      hi_prod_q;
  logic                    out_valid_q;
  cmf_out_t                out_q;

  logic [COL_W:0]          w;
  logic [3:0]              kc, kr;
  logic [2:0]              ac, ar;
  logic [COL_W-1:0]        wm1, sx_col;
  logic signed [COL_W+2:0] sx;
  logic                    last_tap, out_load;

  logic                    line_we, wt_we;
  logic [LINE_AW-1:0]      line_waddr, line_raddr;
  logic [31:0]             line_rdata;
  logic [19:0]             wt_rdata;

  logic signed [ACC_W-1:0] acc_sel;
  logic signed [60:0]      vsum;
  logic [7:0]              chan_val;

  always_comb begin
    w   = eff_width(cfg_i.frame_width);
    kc  = eff_size(cfg_i.kernel_cols);
    kr  = eff_size(cfg_i.kernel_rows);
    ac  = eff_anchor(cfg_i.anchor_col, kc);
    ar  = eff_anchor(cfg_i.anchor_row, kr);
    wm1 = COL_W'(w - (COL_W+1)'(1));
  end

  // Source column of the current tap, clamped to the row
  always_comb begin
    sx = $signed({3'b0, x_q}) + $signed({{COL_W{1'b0}}, kx_q})
       - $signed({{COL_W{1'b0}}, ac});
    if (sx < 0) begin
      sx_col = '0;
    end else if (sx > $signed({2'b0, w}) - 1) begin
      sx_col = wm1;
    end else begin
      sx_col = COL_W'(sx);
    end
    last_tap = ({1'b0, kx_q} == kc - 4'd1) && ({1'b0, ky_q} == kr - 4'd1);
    out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (cmd_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (cmd_q.op == OP_WEIGHT || cmd_q.count == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_TAP;
        end
      end
      S_TAP:    if (last_tap) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_ALPHA;
      S_ALPHA:  state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_SUM;
      S_SUM:    state_d = (ch_q == 2'd3) ? S_OUT : S_MUL_LO;
      S_OUT: begin
        if (out_load) begin
          state_d = (cnt_q == CNT_W'(1)) ? S_IDLE : S_TAP;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Memory controls and queue pop
  always_comb begin
    cmd_ready_o = 1'b0;
    line_we     = 1'b0;
    wt_we       = 1'b0;
    line_waddr  = {cmd_q.slot, cmd_q.col};
    line_raddr  = {slot_q, sx_col};
    case (state_q)
      S_IDLE:  cmd_ready_o = 1'b1;
      S_EXEC: begin
        line_we = (cmd_q.op == OP_PIXEL);
        wt_we   = (cmd_q.op == OP_WEIGHT);
      end
      S_DRAIN: line_raddr = {SLOT_W'(base_q + SLOT_W'(ar)), x_q};
      default: line_raddr = {slot_q, sx_col};
    endcase
  end

  // Channel finish: scale, add bias, round, clamp
  always_comb begin
    acc_sel = acc_q[ch_q];
    vsum = (61'(hi_prod_q) <<< 17) + 61'(lo_prod_q)
         + (61'(cfg_i.bias_offset) <<< 20) + (61'sd1 <<< 27);
    if (vsum < 0) begin
      chan_val = 8'd0;
    end else if (|vsum[60:36]) begin
      chan_val = 8'hFF;
    end else begin
      chan_val = vsum[35:28];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_vld_q <= (state_q == S_TAP);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    // start of a new output pixel
    if (state_q == S_EXEC || (out_load && cnt_q != CNT_W'(1))) begin
      kx_q   <= '0;
      ky_q   <= '0;
      widx_q <= '0;
      for (int i = 0; i < 4; i++) acc_q[i] <= '0;
      if (state_q == S_EXEC) begin
        x_q    <= cmd_q.first;
        cnt_q  <= cmd_q.count;
        base_q <= SLOT_W'(cmd_q.slot - SLOT_W'(kr - 4'd1));
        slot_q <= SLOT_W'(cmd_q.slot - SLOT_W'(kr - 4'd1));
      end else begin
        x_q    <= x_q + COL_W'(1);
        cnt_q  <= cnt_q - CNT_W'(1);
        slot_q <= base_q;
      end
    end else begin
      if (state_q == S_TAP) begin
        widx_q <= widx_q + WT_AW'(1);
        if ({1'b0, kx_q} == kc - 4'd1) begin
          kx_q   <= '0;
          ky_q   <= ky_q + 3'd1;
          slot_q <= slot_q + SLOT_W'(1);
        end else begin
          kx_q <= kx_q + 3'd1;
        end
      end
      if (tap_vld_q) begin
        for (int i = 0; i < 4; i++) begin
          acc_q[i] <= acc_q[i] + ACC_W'($signed({1'b0, line_rdata[8*i +: 8]})
                                        * $signed(wt_rdata));
        end
      end
    end
    if (state_q == S_ALPHA) begin
      alpha_q <= line_rdata;
      ch_q    <= 2'd0;
    end
    if (state_q == S_MUL_LO) begin
      lo_prod_q <= $signed({1'b0, acc_sel[16:0]}) * cfg_i.divisor_reciprocal;
    end
    if (state_q == S_MUL_HI) begin
      hi_prod_q <= $signed(acc_sel[ACC_W-1:17]) * cfg_i.divisor_reciprocal;
    end
    if (state_q == S_SUM) begin
      res_q[ch_q] <= chan_val;
      ch_q        <= ch_q + 2'd1;
    end
    if (out_load) begin
      out_q.pixel_out <= {cfg_i.keep_alpha ? alpha_q[31:24] : res_q[3],
                          res_q[2], res_q[1], res_q[0]};
      out_q.out_col   <= 11'(x_q);
      out_q.out_row   <= 16'(cmd_q.orow);
      out_q.last      <= (cnt_q == CNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Line buffer ring
  cmf_ram #(
    .WIDTH (32),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (cmd_q.pixel),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // Kernel weights
  cmf_ram #(
    .WIDTH (20),
    .DEPTH (WT_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (cmd_q.widx),
    .wdata_i (cmd_q.wval),
    .raddr_i (widx_q),
    .rdata_o (wt_rdata)
  );

  `CMF_ASSERT(back_tap_window, tap_vld_q |-> state_q == S_DRAIN || state_q == S_TAP)
  `CMF_ASSERT(back_out_from_out, $rose(out_valid_q) |-> $past(state_q) == S_OUT)
  `CMF_NEVER(back_out_no_work, state_q == S_OUT && cnt_q == '0)

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the streaming ARGB convolution filter.
`timescale 1ns / 100ps

module testbench;
  import cmf_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  cmf_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  cmf_out_t out_data_o;
  logic     psel = 1'b0;
  logic     penable = 1'b0;
  logic     pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  convolve_matrix_filter_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and register shadow
  cmf_cfg_t    shadow;
  logic [31:0] line_mem [MAX_WIDTH*MAX_ORDER];
  int          kern [64];
  int unsigned col_cnt, row_cnt, slot_ptr;

  cmf_in_t  pending_items [$];
  cmf_out_t expected_pixels [$];
  int       fail_count = 0;
  bit       sink_quiet = 1'b0;
  bit       sink_holdoff = 1'b0;
  int       holdoff_left = 0;
  bit       src_pause = 1'b0;

  int unsigned eff_w, eff_kc, eff_kr, eff_ac, eff_ar;

  function automatic logic [7:0] scale_channel(longint acc);
    longint v;
    v = acc * longint'(shadow.divisor_reciprocal)
      + longint'(shadow.bias_offset) * (64'sd1 <<< 20) + (64'sd1 <<< 27);
    if (v < 0) return 8'd0;
    v = v >>> 28;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [31:0] filter_pixel(int unsigned x);
    longint acc [4];
    int unsigned s, ky, kx, ch;
    int sx;
    logic [31:0] p, res;
    for (ch = 0; ch < 4; ch++) acc[ch] = 0;
    for (ky = 0; ky < eff_kr; ky++) begin
      s = (slot_ptr + MAX_ORDER - (eff_kr - 1 - ky)) % MAX_ORDER;
      for (kx = 0; kx < eff_kc; kx++) begin
        sx = int'(x) + int'(kx) - int'(eff_ac);
        if (sx < 0) sx = 0;
        if (sx > int'(eff_w) - 1) sx = int'(eff_w) - 1;
        p = line_mem[s*MAX_WIDTH + sx];
        for (ch = 0; ch < 4; ch++)
          acc[ch] += longint'(p[8*ch +: 8]) * longint'(kern[(ky*eff_kc + kx) & 63]);
      end
    end
    res = '0;
    for (ch = 0; ch < 3; ch++) res[8*ch +: 8] = scale_channel(acc[ch]);
    if (shadow.keep_alpha) begin
      s = (slot_ptr + MAX_ORDER - (eff_kr - 1 - eff_ar)) % MAX_ORDER;
      res[31:24] = line_mem[s*MAX_WIDTH + x][31:24];
    end else begin
      res[31:24] = scale_channel(acc[3]);
    end
    return res;
  endfunction

  // Model one accepted item, pushing its expected pixels
  task automatic predict_item(cmf_in_t it);
    int unsigned c, d, first, x, n;
    cmf_out_t r;
    if (it.operation == OP_WEIGHT) begin
      kern[it.weight_index] = int'(it.weight_value);
      return;
    end
    if (it.start_of_frame) begin
      col_cnt = 0; row_cnt = 0; slot_ptr = 0;
    end
    eff_w  = (shadow.frame_width == 0) ? 1 :
             (shadow.frame_width > MAX_WIDTH ? MAX_WIDTH : shadow.frame_width);
    eff_kc = (shadow.kernel_cols == 0) ? 1 :
             (shadow.kernel_cols > MAX_ORDER ? MAX_ORDER : shadow.kernel_cols);
    eff_kr = (shadow.kernel_rows == 0) ? 1 :
             (shadow.kernel_rows > MAX_ORDER ? MAX_ORDER : shadow.kernel_rows);
    eff_ac = (shadow.anchor_col < eff_kc) ? shadow.anchor_col : eff_kc - 1;
    eff_ar = (shadow.anchor_row < eff_kr) ? shadow.anchor_row : eff_kr - 1;
    c = (col_cnt >= eff_w) ? eff_w - 1 : col_cnt;
    line_mem[slot_ptr*MAX_WIDTH + c] = it.pixel_in;
    n = 0;
    if (row_cnt >= eff_kr - 1) begin
      d = eff_kc - 1 - eff_ac;
      first = (c == eff_w - 1) ? ((c >= d) ? c - d : 0) : c - d;
      if (c == eff_w - 1 || c >= d) begin
        for (x = first; x < ((c == eff_w - 1) ? eff_w : first + 1); x++) begin
          r.pixel_out = filter_pixel(x);
          r.out_col   = x[10:0];
          r.out_row   = 16'(row_cnt - (eff_kr - 1 - eff_ar));
          r.last      = (c == eff_w - 1) ? (x == eff_w - 1) : 1'b1;
          expected_pixels.push_back(r);
        end
      end
    end
    if (c == eff_w - 1) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 16'hFFFF;
      slot_ptr = (slot_ptr + 1) % MAX_ORDER;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Driver: offers queued items with random idle bursts
  int src_gap = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_item(in_data_i);
      void'(pending_items.pop_front());
    end
    if (in_valid_i && !in_ready_o) begin
      // hold the current item
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      in_valid_i <= 1'b0;
    end else if (pending_items.size() > 0 && !src_pause) begin
      if (!sink_quiet && $urandom_range(0, 5) == 0) begin
        src_gap <= $urandom_range(1, 7) - 1;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor and sink stalls
  int sink_gap = 0;
  always @(posedge clk_i) begin
    cmf_out_t w;
    if (out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.pixel_out, '0);
      end else begin
        w = expected_pixels.pop_front();
        if (out_data_o.pixel_out !== w.pixel_out)
          report_mismatch("pixel_out", out_data_o.pixel_out, w.pixel_out);
        if (out_data_o.out_col !== w.out_col)
          report_mismatch("out_col", 32'(out_data_o.out_col), 32'(w.out_col));
        if (out_data_o.out_row !== w.out_row)
          report_mismatch("out_row", 32'(out_data_o.out_row), 32'(w.out_row));
        if (out_data_o.last !== w.last)
          report_mismatch("last", 32'(out_data_o.last), 32'(w.last));
      end
    end
    if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready_i <= 1'b0;
    end else if (sink_holdoff) begin
      holdoff_left <= 400;
      out_ready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!sink_quiet && $urandom_range(0, 4) == 0) begin
      sink_gap <= $urandom_range(1, 7) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer or register access
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: shadow.frame_width = val[11:0];
      REG_KERNEL_COLS: shadow.kernel_cols = val[3:0];
      REG_KERNEL_ROWS: shadow.kernel_rows = val[3:0];
      REG_ANCHOR_COL:  shadow.anchor_col = val[2:0];
      REG_ANCHOR_ROW:  shadow.anchor_row = val[2:0];
      REG_DIV_RECIP:   shadow.divisor_reciprocal = val[24:0];
      REG_BIAS:        shadow.bias_offset = val[19:0];
      default:         shadow.keep_alpha = val[0];
    endcase
  endtask

  // Wait until the block has drained, then let the back end settle
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (8 * (64 + 17) + 20) @(posedge clk_i);
  endtask

  function automatic cmf_in_t weight_item(int idx, int val);
    cmf_in_t it;
    it = '0;
    it.operation = OP_WEIGHT;
    it.weight_index = idx[5:0];
    it.weight_value = val[19:0];
    it.pixel_in = $urandom();
    it.start_of_frame = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic cmf_in_t pixel_item(logic [31:0] p, bit sof);
    cmf_in_t it;
    it = '0;
    it.operation = OP_PIXEL;
    it.pixel_in = p;
    it.start_of_frame = sof;
    it.weight_index = $urandom();
    it.weight_value = $urandom();
    return it;
  endfunction

  // Load the taps the kernel uses, then a frame of rows
  task automatic queue_frame(int w, int rows, int taps, bit wild_weights);
    int i;
    for (i = 0; i < taps; i++)
      pending_items.push_back(weight_item(i, wild_weights ?
        int'($urandom()) : int'($urandom_range(0, 8192)) - 2048));
    for (i = 0; i < w * rows; i++)
      pending_items.push_back(pixel_item($urandom(), i == 0));
  endtask

  initial begin
    int ph;
    logic [31:0] v;
    shadow = '{frame_width: 12'd1, kernel_cols: 4'd3, kernel_rows: 4'd3,
               anchor_col: 3'd1, anchor_row: 3'd1,
               divisor_reciprocal: 25'sd65536, bias_offset: '0, keep_alpha: 1'b0};
    col_cnt = 0; row_cnt = 0; slot_ptr = 0;
    foreach (kern[i]) kern[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default 3x3 on a width-5 frame with extreme pixels
    write_reg(REG_FRAME_WIDTH, 32'd5);
    for (int i = 0; i < 9; i++) pending_items.push_back(weight_item(i, 4096));
    for (int i = 0; i < 15; i++)
      pending_items.push_back(pixel_item((i % 3 == 0) ? 32'hFFFFFFFF :
                                         (i % 3 == 1) ? 32'h0 : $urandom(), i == 0));
    wait_drained();

    // Extremes: 1x1 kernel, zero width, keep alpha, big bias, large gain
    write_reg(REG_FRAME_WIDTH, 32'd0);
    write_reg(REG_KERNEL_COLS, 32'd1);
    write_reg(REG_KERNEL_ROWS, 32'd0);
    write_reg(REG_ANCHOR_COL, 32'd7);
    write_reg(REG_ANCHOR_ROW, 32'd0);
    write_reg(REG_KEEP_ALPHA, 32'd1);
    write_reg(REG_BIAS, 32'h7FFFF);
    write_reg(REG_DIV_RECIP, 32'h0FFFFFF);
    queue_frame(1, 4, 1, 1'b1);
    wait_drained();

    // Negative extremes, oversized kernel, eight results from one row end
    write_reg(REG_KERNEL_COLS, 32'd15);
    write_reg(REG_KERNEL_ROWS, 32'd2);
    write_reg(REG_ANCHOR_COL, 32'd0);
    write_reg(REG_ANCHOR_ROW, 32'd7);
    write_reg(REG_FRAME_WIDTH, 32'd9);
    write_reg(REG_DIV_RECIP, 32'h1000000);
    write_reg(REG_BIAS, 32'h80000);
    write_reg(REG_KEEP_ALPHA, 32'd0);
    queue_frame(9, 2, 16, 1'b1);
    wait_drained();

    // Random phases; one with a long output hold-off, one with the sender paused,
    // the last one on an oversized width with no idling
    for (ph = 0; ph < 4; ph++) begin
      int w, kc, kr, rows;
      w = $urandom_range(1, 6); kc = $urandom_range(1, 3); kr = $urandom_range(1, 3);
      if (ph == 1 && w < 4) w = 4;
      rows = kr + 1;
      if (ph == 3) kr = 1;
      write_reg(REG_FRAME_WIDTH, (ph == 3) ? 32'hFFF : 32'(w));
      write_reg(REG_KERNEL_COLS, kc);
      write_reg(REG_KERNEL_ROWS, kr);
      write_reg(REG_ANCHOR_COL, $urandom_range(0, 7));
      write_reg(REG_ANCHOR_ROW, $urandom_range(0, 7));
      v = $urandom_range(0, 131072) - 65536;
      write_reg(REG_DIV_RECIP, v);
      write_reg(REG_BIAS, $urandom_range(0, 65535) - 32768);
      write_reg(REG_KEEP_ALPHA, $urandom_range(0, 1));
      sink_quiet = (ph == 3);
      if (ph == 3) begin
        // wide frame: only the start of one row so the run stays bounded
        queue_frame(12, 1, kc * kr, 1'b0);
      end else begin
        queue_frame(w, rows, kc * kr, 1'b0);
      end
      if (ph == 1) begin
        sink_holdoff = 1'b1;
        @(posedge clk_i);
        @(posedge clk_i);
        sink_holdoff = 1'b0;
      end
      if (ph == 2) begin
        while (pending_items.size() > 4) @(posedge clk_i);
        src_pause = 1'b1;
        while (expected_pixels.size() != 0 || in_valid_i) @(posedge clk_i);
        src_pause = 1'b0;
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
